@@ rtl/lps_pkg.sv @@
// Shared types, constants and the sharpening kernel for the 3x3 Laplacian core.
// No dependencies; used by lps_front, lps_back and the top level (lps_queue does not use it).
`timescale 1ns / 1ps

package lps_pkg;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATE_MODE = 2'd2;

    localparam logic [DIM_W-1:0] DEF_FRAME_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] DEF_FRAME_HEIGHT = 12'd480;

    // Input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Classification of one queued item
    typedef struct packed {
        logic drain;    // flush item copying a pending pixel out of the line stores
        logic fire;     // item produces a result
        logic border;   // result is a copied border pixel
        logic sel_mid;  // drain reads the middle line (last row) instead of upper
        logic last;     // result is the final pixel of the frame
    } t_item_flags;

    // 5*c - (u + d + l + r), wrapped to 8 bits or clamped to 0..255
    function automatic logic [PIX_W-1:0] laplace(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] u,
        input logic [PIX_W-1:0] d,
        input logic [PIX_W-1:0] l,
        input logic [PIX_W-1:0] r,
        input logic             sat
    );
        logic        [10:0] five_c;
        logic        [9:0]  nsum;
        logic signed [11:0] v;
        logic [PIX_W-1:0]   res;
        five_c = {1'b0, c, 2'b00} + {3'b000, c};
        nsum   = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
        v      = signed'({1'b0, five_c}) - signed'({2'b00, nsum});
        res    = v[PIX_W-1:0];
        if (sat) begin
            if (v < 0) begin
                res = '0;
            end else if (v > 12'sd255) begin
                res = '1;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/lps_queue.sv @@
// Small register FIFO decoupling the classifier front from the filter back end.
// Depends on nothing; width and depth come in as parameters.
`timescale 1ns / 1ps

module lps_queue #(
    parameter int DATA_W = 22,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

@@ rtl/lps_front.sv @@
// Front end: accepts input transactions, tracks input and output raster position,
// classifies each item and pushes it to the queue. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lps_pkg::DIM_W-1:0]     i_frame_width,
    input  logic [lps_pkg::DIM_W-1:0]     i_frame_height,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [lps_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_full,
    output logic                          o_push,
    output lps_pkg::t_item_flags          o_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output logic [lps_pkg::PIX_W-1:0]     o_pixel
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = CW + 1;
    localparam int HEW = RW + 1;

    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;

    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic          r_draining, n_draining;

    logic accept, emit, in_col_end, in_row_end, out_col_end, out_row_end, out_last;
    logic fire, inner;

    // Effective geometry: zero reads as one, oversize clamps to the maximum
    always_comb begin
        if (i_frame_width == '0) begin
            w_eff = WEW'(1);
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            h_eff = HEW'(1);
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = HEW'(i_frame_height);
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Position tests
    assign in_col_end  = ({1'b0, r_in_col} + 1'b1)  >= w_eff;
    assign in_row_end  = ({1'b0, r_in_row} + 1'b1)  >= h_eff;
    assign out_col_end = ({1'b0, r_out_col} + 1'b1) >= w_eff;
    assign out_row_end = ({1'b0, r_out_row} + 1'b1) >= h_eff;
    assign out_last    = out_col_end && out_row_end;

    // A pixel yields a result once one line plus one pixel has arrived
    assign fire  = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);
    assign inner = (r_out_row != '0) && !out_row_end && (r_out_col != '0) && !out_col_end;

    // Classification and next position
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_draining = r_draining;
        o_push     = 1'b0;
        o_flags    = '0;
        o_col      = r_in_col;
        o_pixel    = i_pixel;
        emit       = 1'b0;
        if (accept) begin
            if (r_draining) begin
                if (i_cmd == lps_pkg::CMD_FLUSH) begin
                    o_push          = 1'b1;
                    o_col           = r_out_col;
                    o_flags.drain   = 1'b1;
                    o_flags.fire    = 1'b1;
                    o_flags.border  = 1'b1;
                    o_flags.sel_mid = out_row_end;
                    o_flags.last    = out_last;
                    emit            = 1'b1;
                end
            end else if (i_cmd == lps_pkg::CMD_PIXEL) begin
                o_push         = 1'b1;
                o_flags.fire   = fire;
                o_flags.border = !inner;
                o_flags.last   = fire && out_last;
                emit           = fire;
                if (in_col_end) begin
                    n_in_col = '0;
                    if (in_row_end) begin
                        n_draining = 1'b1;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
            if (emit) begin
                if (out_last) begin
                    n_in_col   = '0;
                    n_in_row   = '0;
                    n_out_col  = '0;
                    n_out_row  = '0;
                    n_draining = 1'b0;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_draining <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_draining <= n_draining;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_flags.last |=> !r_draining && r_out_col == '0 && r_out_row == '0
                                   && r_in_col == '0 && r_in_row == '0)
        else $error("frame did not restart after last pixel");

    a_drain_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> r_in_col == '0)
        else $error("input column not at zero while draining");

endmodule

@@ rtl/lps_back.sv @@
// Back end: line stores, 3x2 window and kernel, plus the registered output stage.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_saturate,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  lps_pkg::t_item_flags          i_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  logic [lps_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lps_pkg::PIX_W-1:0]     o_pixel,
    output logic                          o_border,
    output logic                          o_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = lps_pkg::PIX_W;

    // Line stores, read-before-write within one item, no reset
    logic [PW-1:0] r_upper_mem  [MAX_WIDTH];
    logic [PW-1:0] r_middle_mem [MAX_WIDTH];
    logic [PW-1:0] r_top_rd, r_mid_rd;

    // Stage after the memory read
    logic                 r_s1_valid;
    lps_pkg::t_item_flags r_s1_flags;
    logic [CW-1:0]        r_s1_col;
    logic [PW-1:0]        r_s1_px;

    // Window: [0..2] newest column top/mid/bottom, [3..5] previous column
    logic [PW-1:0] r_win [6];

    logic          r_out_valid, r_out_border, r_out_last;
    logic [PW-1:0] r_out_pixel;

    logic          adv, wr_en;
    logic [PW-1:0] result;

    // Whole back end moves when the output register is free or being taken
    assign adv   = !r_out_valid || i_ready;
    assign o_pop = adv && !i_empty;
    assign wr_en = adv && r_s1_valid && !r_s1_flags.drain;

    // Result of the item in the stage
    always_comb begin
        if (r_s1_flags.drain) begin
            result = r_s1_flags.sel_mid ? r_mid_rd : r_top_rd;
        end else if (r_s1_flags.border) begin
            result = r_win[1];
        end else begin
            result = lps_pkg::laplace(r_win[1], r_win[0], r_win[2], r_win[4], r_mid_rd,
                                      i_saturate);
        end
    end

    // Line store write and read, forwarding a same-column write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_upper_mem[r_s1_col]  <= r_mid_rd;
            r_middle_mem[r_s1_col] <= r_s1_px;
        end
        if (o_pop) begin
            if (wr_en && r_s1_col == i_col) begin
                r_top_rd <= r_mid_rd;
                r_mid_rd <= r_s1_px;
            end else begin
                r_top_rd <= r_upper_mem[i_col];
                r_mid_rd <= r_middle_mem[i_col];
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_flags <= i_flags;
            r_s1_col   <= i_col;
            r_s1_px    <= i_pixel;
        end
    end

    // Stage valid, window and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (adv) begin
                r_s1_valid  <= o_pop;
                r_out_valid <= r_s1_valid && r_s1_flags.fire;
            end
            if (wr_en) begin
                r_win[3] <= r_win[0];
                r_win[4] <= r_win[1];
                r_win[5] <= r_win[2];
                r_win[2] <= r_s1_px;
                r_win[0] <= r_top_rd;
                r_win[1] <= r_mid_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pixel  <= result;
            r_out_border <= r_s1_flags.border;
            r_out_last   <= r_s1_flags.last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_pixel  = r_out_pixel;
    assign o_border = r_out_border;
    assign o_last   = r_out_last;

    a_drain_gives_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s1_valid && r_s1_flags.drain |=> r_out_valid && r_out_border)
        else $error("drain item did not produce a border result");

endmodule

@@ rtl/laplacian_sharpen_3x3_core.sv @@
// Top level of the 3x3 Laplacian sharpening core: configuration registers and the
// front / queue / back pipeline. Depends on lps_pkg, lps_front, lps_queue, lps_back.
`timescale 1ns / 1ps

// Usage:
//  - Slave stream: one transaction per input item. tuser = 0 carries a pixel in
//    tdata, tuser = 1 is a flush that drains one pending pixel after the frame end.
//  - Master stream: one transaction per result; tuser marks a copied border pixel,
//    tlast marks the final pixel of the frame.
//  - Config channel: index 0 frame width, 1 frame height, 2 saturate mode; write
//    only while the core is idle. Ready is always high.
//  - Throughput: one item per clock, sustained while the master side takes results. A result for pixel n appears after
//    pixel n + width + 1 has been accepted; the last width + 1 pixels of a frame
//    leave on flush items, one per flush.
//  - Path: the result released by an accepted item passes through the queue
//    write, the line store read and the output register, in that order.
//  - Reset clears counters and the window and restores default geometry
//    (640 x 480, wrap mode). The line stores are not cleared.
//  - A stalled master side holds the output register; the 4-entry queue keeps
//    taking items until it fills, then slave tready drops.

module laplacian_sharpen_3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lps_pkg::DIM_W-1:0]         i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_in
    input  logic                              s_axis_tuser,   // [0] cmd
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] pixel_out
    output logic                              m_axis_tuser,   // [0] is_border
    output logic                              m_axis_tlast
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int PW  = lps_pkg::PIX_W;
    localparam int FW  = $bits(lps_pkg::t_item_flags);
    localparam int QDW = FW + CW + PW;

    logic [lps_pkg::DIM_W-1:0] r_frame_width, r_frame_height;
    logic                      r_saturate;

    logic                 push, pop, q_full, q_empty;
    lps_pkg::t_item_flags f_flags, b_flags;
    logic [CW-1:0]        f_col, b_col;
    logic [PW-1:0]        f_px, b_px;
    logic [QDW-1:0]       q_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lps_pkg::DEF_FRAME_WIDTH;
            r_frame_height <= lps_pkg::DEF_FRAME_HEIGHT;
            r_saturate     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lps_pkg::CFG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data;
                lps_pkg::CFG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data;
                lps_pkg::CFG_SATURATE_MODE: r_saturate     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_cmd          (s_axis_tuser),
        .i_pixel        (s_axis_tdata),
        .i_full         (q_full),
        .o_push         (push),
        .o_flags        (f_flags),
        .o_col          (f_col),
        .o_pixel        (f_px)
    );

    lps_queue #(
        .DATA_W (QDW),
        .DEPTH  (lps_pkg::Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_col, f_px}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign b_flags = lps_pkg::t_item_flags'(q_out[QDW-1 -: FW]);
    assign b_col   = q_out[PW +: CW];
    assign b_px    = q_out[PW-1:0];

    lps_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_saturate (r_saturate),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .i_flags    (b_flags),
        .i_col      (b_col),
        .i_pixel    (b_px),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pixel    (m_axis_tdata),
        .o_border   (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule
